[hw/rtl/rv32i_subset_single_cycle_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the RV32I subset core
// Shared helpers that wrap concurrent assertions; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RV32I_SUBSET_SINGLE_CYCLE_CORE_DEFINES_SVH
`define RV32I_SUBSET_SINGLE_CYCLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define RVC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("core assertion failed");
// condition must never be seen out of reset
`define RVC_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (!(cond))) \
		else $error("core forbidden condition seen");
`else
`define RVC_ASSERT(lbl, clk, rstn, prop)
`define RVC_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[hw/rtl/rvc_pkg.sv]
// ----------------------------------------------------------------------------
// rvc_pkg
// Types, opcodes and constants shared by the RV32I subset core.
// ----------------------------------------------------------------------------
`default_nettype none
package rvc_pkg;

	// data store size in bytes; addresses wrap at this power of two
	localparam int DATA_BYTES = 4096;
	localparam int DMEM_AW    = $clog2(DATA_BYTES);

	localparam logic [31:0] SP_RESET = 32'd4095;
	localparam logic [31:0] JALR_MASK = 32'hffff_fffe;

	// major opcodes
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_IMM    = 7'b0010011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_REG    = 7'b0110011;

	typedef enum logic [2:0] {
		CLS_NOP, CLS_ALU, CLS_BRANCH, CLS_JAL, CLS_JALR, CLS_LOAD, CLS_STORE
	} cls_t;

	typedef enum logic [2:0] {
		ALU_ADD, ALU_SUB, ALU_SLL, ALU_SRL, ALU_XOR, ALU_OR, ALU_AND, ALU_MUL
	} alu_op_t;

	typedef enum logic [1:0] {
		BR_EQ, BR_NE, BR_LT, BR_GE
	} br_op_t;

	// decoded instruction word, front to back
	typedef struct packed {
		cls_t        cls;
		alu_op_t     alu;
		br_op_t      br;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [4:0]  rd;
		logic [31:0] imm;
		logic        use_imm;
		logic        ld_sext;
		logic        wr;
		logic        bad;
	} dec_t;

	// reset contents of the register file
	function automatic logic [31:0] rf_reset_val(input logic [4:0] idx);
		return (idx == 5'd2) ? SP_RESET : 32'd0;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/rvc_ram.sv]
// ----------------------------------------------------------------------------
// rvc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module rvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[hw/rtl/rvc_front.sv]
// ----------------------------------------------------------------------------
// rvc_front
// Accepts instruction words and decodes them into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none
module rvc_front (
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] instr_word,
	input  wire logic        q_full,
	input  wire logic        busy,
	output logic             push,
	output rvc_pkg::dec_t    push_data
);
	import rvc_pkg::*;

	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i, imm_s, imm_b, imm_j;
	logic        wr_any;

	assign op = instr_word[6:0];
	assign f3 = instr_word[14:12];
	assign f7 = instr_word[31:25];

	assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
	assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
	assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
		instr_word[30:25], instr_word[11:8], 1'b0};
	assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
		instr_word[20], instr_word[30:21], 1'b0};

	assign in_stall = q_full | busy;
	assign push     = in_valid & ~in_stall;

	// classify the word
	always_comb begin
		push_data         = '0;
		push_data.cls     = CLS_NOP;
		push_data.alu     = ALU_ADD;
		push_data.br      = BR_EQ;
		push_data.rs1     = instr_word[19:15];
		push_data.rs2     = instr_word[24:20];
		push_data.imm     = imm_i;
		wr_any            = 1'b0;
		case (op)
			OPC_REG: begin
				push_data.cls = CLS_ALU;
				wr_any = 1'b1;
				if (f7 == 7'h00) begin
					case (f3)
						3'd0: push_data.alu = ALU_ADD;
						3'd1: push_data.alu = ALU_SLL;
						3'd4: push_data.alu = ALU_XOR;
						3'd5: push_data.alu = ALU_SRL;
						3'd6: push_data.alu = ALU_OR;
						3'd7: push_data.alu = ALU_AND;
						default: push_data.bad = 1'b1;
					endcase
				end else if (f7 == 7'h20 && f3 == 3'd0) begin
					push_data.alu = ALU_SUB;
				end else if (f7 == 7'h01 && f3 == 3'd0) begin
					push_data.alu = ALU_MUL;
				end else begin
					push_data.bad = 1'b1;
				end
			end
			OPC_IMM: begin
				push_data.cls = CLS_ALU;
				push_data.use_imm = 1'b1;
				wr_any = 1'b1;
				case (f3)
					3'd0: push_data.alu = ALU_ADD;
					3'd4: push_data.alu = ALU_XOR;
					3'd6: push_data.alu = ALU_OR;
					3'd7: push_data.alu = ALU_AND;
					3'd1: begin
						push_data.alu = ALU_SLL;
						push_data.bad = (f7 != 7'h00);
					end
					3'd5: begin
						push_data.alu = ALU_SRL;
						push_data.bad = (f7 != 7'h00);
					end
					default: push_data.bad = 1'b1;
				endcase
			end
			OPC_BRANCH: begin
				push_data.cls = CLS_BRANCH;
				push_data.imm = imm_b;
				case (f3)
					3'd0: push_data.br = BR_EQ;
					3'd1: push_data.br = BR_NE;
					3'd4: push_data.br = BR_LT;
					3'd5: push_data.br = BR_GE;
					default: push_data.bad = 1'b1;
				endcase
			end
			OPC_JAL: begin
				push_data.cls = CLS_JAL;
				push_data.imm = imm_j;
				wr_any = 1'b1;
			end
			OPC_JALR: begin
				push_data.cls = CLS_JALR;
				wr_any = 1'b1;
				push_data.bad = (f3 != 3'd0);
			end
			OPC_LOAD: begin
				push_data.cls = CLS_LOAD;
				push_data.ld_sext = (f3 == 3'd0);
				wr_any = 1'b1;
				push_data.bad = !(f3 == 3'd0 || f3 == 3'd4);
			end
			OPC_STORE: begin
				push_data.cls = CLS_STORE;
				push_data.imm = imm_s;
				push_data.bad = (f3 != 3'd0);
			end
			default: push_data.bad = 1'b1;
		endcase
		// unsupported words only step the PC
		if (push_data.bad) begin
			push_data.cls = CLS_NOP;
		end
		push_data.wr = wr_any & ~push_data.bad & (instr_word[11:7] != 5'd0);
		push_data.rd = push_data.wr ? instr_word[11:7] : 5'd0;
	end
endmodule
`default_nettype wire

[hw/rtl/rvc_queue.sv]
// ----------------------------------------------------------------------------
// rvc_queue
// Two-entry queue of decoded words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module rvc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire rvc_pkg::dec_t  push_data,
	input  wire logic           pop,
	output rvc_pkg::dec_t       head,
	output logic                empty,
	output logic                full
);
	import rvc_pkg::*;

	dec_t       ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign head  = ent_q[rd_ptr_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/rvc_back.sv]
// ----------------------------------------------------------------------------
// rvc_back
// Issue, execute and writeback against register file, PC and data store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rv32i_subset_single_cycle_core_defines.svh"
module rvc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rvc_pkg::dec_t head,
	input  wire logic          q_empty,
	output logic               pop,
	output logic               busy,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [31:0]        next_pc,
	output logic               reg_written,
	output logic [4:0]         dest_index,
	output logic [31:0]        dest_value,
	output logic               unsupported
);
	import rvc_pkg::*;

	typedef struct packed {
		logic        wr;
		logic [4:0]  rd;
		logic [31:0] val;
		logic        is_ld;
		logic        ld_sext;
		logic [31:0] npc;
		logic        bad;
	} ex_t;

	typedef struct packed {
		logic        we;
		logic [4:0]  rd;
		logic [31:0] val;
	} wb_t;

	logic               adv;
	logic               clearing_q;
	logic [DMEM_AW-1:0] clr_idx_q;
	logic [31:0]        pc_q;
	logic [31:0]        rf_valid_q;

	dec_t               d_s1;
	logic               v_s1;
	logic               rv1_s1, rv2_s1;
	ex_t                e_s2;
	logic               v_s2;
	wb_t                w_s3;

	logic [31:0]        rf_rd1, rf_rd2;
	logic [7:0]         dm_rd;
	logic               rf_we;
	logic [4:0]         rf_waddr;
	logic [31:0]        fin_val;

	logic [31:0]        a, b, opb, alu_res, npc, addr;
	logic               take;
	ex_t                ex;
	logic               dm_we;
	logic [DMEM_AW-1:0] dm_waddr;
	logic [7:0]         dm_wdata;

	assign adv  = !out_valid || !out_stall;
	assign busy = clearing_q;
	assign pop  = adv && !q_empty && !clearing_q;

	// finish stage: load data selection and register write
	always_comb begin
		if (e_s2.is_ld) begin
			fin_val = e_s2.ld_sext ? {{24{dm_rd[7]}}, dm_rd} : {24'd0, dm_rd};
		end else begin
			fin_val = e_s2.val;
		end
	end
	assign rf_we    = adv && v_s2 && e_s2.wr;
	assign rf_waddr = e_s2.rd;

	// operand forwarding: finish stage, then last written, then file
	always_comb begin
		if (v_s2 && e_s2.wr && e_s2.rd == d_s1.rs1) begin
			a = fin_val;
		end else if (w_s3.we && w_s3.rd == d_s1.rs1) begin
			a = w_s3.val;
		end else begin
			a = rv1_s1 ? rf_rd1 : rf_reset_val(d_s1.rs1);
		end
		if (v_s2 && e_s2.wr && e_s2.rd == d_s1.rs2) begin
			b = fin_val;
		end else if (w_s3.we && w_s3.rd == d_s1.rs2) begin
			b = w_s3.val;
		end else begin
			b = rv2_s1 ? rf_rd2 : rf_reset_val(d_s1.rs2);
		end
	end

	// execute
	assign opb  = d_s1.use_imm ? d_s1.imm : b;
	assign addr = a + d_s1.imm;
	always_comb begin
		case (d_s1.alu)
			ALU_ADD: alu_res = a + opb;
			ALU_SUB: alu_res = a - opb;
			ALU_SLL: alu_res = a << opb[4:0];
			ALU_SRL: alu_res = a >> opb[4:0];
			ALU_XOR: alu_res = a ^ opb;
			ALU_OR:  alu_res = a | opb;
			ALU_AND: alu_res = a & opb;
			ALU_MUL: alu_res = a * opb;
			default: alu_res = '0;
		endcase
		case (d_s1.br)
			BR_EQ:   take = (a == b);
			BR_NE:   take = (a != b);
			BR_LT:   take = ($signed(a) < $signed(b));
			BR_GE:   take = !($signed(a) < $signed(b));
			default: take = 1'b0;
		endcase
		npc        = pc_q + 32'd4;
		ex         = '0;
		ex.wr      = d_s1.wr;
		ex.rd      = d_s1.rd;
		ex.ld_sext = d_s1.ld_sext;
		ex.bad     = d_s1.bad;
		case (d_s1.cls)
			CLS_ALU:    ex.val = alu_res;
			CLS_BRANCH: if (take) npc = pc_q + d_s1.imm;
			CLS_JAL: begin
				ex.val = pc_q + 32'd4;
				npc    = pc_q + d_s1.imm;
			end
			CLS_JALR: begin
				ex.val = pc_q + 32'd4;
				npc    = addr & JALR_MASK;
			end
			CLS_LOAD:   ex.is_ld = 1'b1;
			default:    ex.val = '0;
		endcase
		ex.npc = npc;
	end

	// data store write port: clearing sweep or byte store
	always_comb begin
		if (clearing_q) begin
			dm_we    = 1'b1;
			dm_waddr = clr_idx_q;
			dm_wdata = '0;
		end else begin
			dm_we    = adv && v_s1 && d_s1.cls == CLS_STORE;
			dm_waddr = addr[DMEM_AW-1:0];
			dm_wdata = b[7:0];
		end
	end

	rvc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(fin_val),
		.re(adv), .raddr(head.rs1), .rdata(rf_rd1)
	);
	rvc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(fin_val),
		.re(adv), .raddr(head.rs2), .rdata(rf_rd2)
	);
	rvc_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_dmem (
		.clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
		.re(adv), .raddr(addr[DMEM_AW-1:0]), .rdata(dm_rd)
	);

	// control: clearing sweep, valid bits, PC, stage valids, last write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
			pc_q       <= '0;
			rf_valid_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			w_s3       <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == DMEM_AW'(DATA_BYTES - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (adv) begin
				v_s1      <= pop;
				v_s2      <= v_s1;
				out_valid <= v_s2;
				w_s3.we   <= rf_we;
				w_s3.rd   <= rf_waddr;
				w_s3.val  <= fin_val;
				if (v_s1) begin
					pc_q <= npc;
				end
				if (rf_we) begin
					rf_valid_q[rf_waddr] <= 1'b1;
				end
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1     <= head;
			rv1_s1   <= rf_valid_q[head.rs1];
			rv2_s1   <= rf_valid_q[head.rs2];
			e_s2     <= ex;
			if (v_s2) begin
				next_pc     <= e_s2.npc;
				reg_written <= e_s2.wr;
				dest_index  <= e_s2.rd;
				dest_value  <= e_s2.wr ? fin_val : 32'd0;
				unsupported <= e_s2.bad;
			end
		end
	end

	`RVC_NEVER(a_x0_never_written, clk, arst_n, rf_we && rf_waddr == 5'd0)
	`RVC_NEVER(a_no_issue_clearing, clk, arst_n, clearing_q && (pop || v_s1))
	`RVC_ASSERT(a_valid_after_write, clk, arst_n, rf_we |=> rf_valid_q[$past(rf_waddr)])
endmodule
`default_nettype wire

[hw/rtl/rv32i_subset_single_cycle_core.sv]
// An accepted word passes the queue, execute stage, finish stage and output register.
// Throughput: one word per cycle unless out_stall or the sweep holds it, set by the
// single execute stage that updates the PC. Reset: PC and register file return to
// reset values at once; the data store is then swept to zero with in_stall high throughout.
// ----------------------------------------------------------------------------
// rv32i_subset_single_cycle_core
// Top level: decoding front, two-entry queue and executing back end.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32i_subset_single_cycle_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] instr_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      next_pc,
	output logic             reg_written,
	output logic [4:0]       dest_index,
	output logic [31:0]      dest_value,
	output logic             unsupported
);
	import rvc_pkg::*;

	dec_t push_data, head;
	logic push, pop, q_empty, q_full, busy;

	rvc_front u_front (
		.in_valid(in_valid), .in_stall(in_stall), .instr_word(instr_word),
		.q_full(q_full), .busy(busy), .push(push), .push_data(push_data)
	);

	rvc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .head(head), .empty(q_empty), .full(q_full)
	);

	rvc_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .q_empty(q_empty), .pop(pop),
		.busy(busy), .out_valid(out_valid), .out_stall(out_stall),
		.next_pc(next_pc), .reg_written(reg_written), .dest_index(dest_index),
		.dest_value(dest_value), .unsupported(unsupported)
	);
endmodule
`default_nettype wire
